// File: rtl/kbc_pkg.sv
// Package for the PS/2 keyboard controller: request kinds, command and reply
// codes, FIFO sizing, the sequencer state type and shared structs.
// No dependencies.
package kbc_pkg;

   // Reply FIFO sizing.
   localparam int FIFO_DEPTH = 256;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = FIFO_AW + 1;

   // Request kinds carried on the request tuser field.
   localparam logic [2:0] KIND_READ_DATA   = 3'd0;
   localparam logic [2:0] KIND_READ_STATUS = 3'd1;
   localparam logic [2:0] KIND_WRITE_DATA  = 3'd2;
   localparam logic [2:0] KIND_WRITE_CMD   = 3'd3;
   localparam logic [2:0] KIND_SCANCODE    = 3'd4;
   localparam logic [2:0] KIND_TICK        = 3'd5;

   // Configuration register indexes.
   localparam logic CSR_DELIVER_DELAY = 1'b0;
   localparam logic CSR_REREAD_DELAY  = 1'b1;

   // Controller commands written to port 64h.
   localparam logic [7:0] CCMD_READ_CMD_BYTE  = 8'h20;
   localparam logic [7:0] CCMD_WRITE_CMD_BYTE = 8'h60;
   localparam logic [7:0] CCMD_TEST_AUX       = 8'hA9;
   localparam logic [7:0] CCMD_SELF_TEST      = 8'hAA;
   localparam logic [7:0] CCMD_TEST_KBD       = 8'hAB;
   localparam logic [7:0] CCMD_DISABLE_KBD    = 8'hAD;
   localparam logic [7:0] CCMD_ENABLE_KBD     = 8'hAE;
   localparam logic [7:0] CCMD_READ_INPUT     = 8'hC0;
   localparam logic [7:0] CCMD_READ_OUTPUT    = 8'hD0;
   localparam logic [7:0] CCMD_WRITE_OUTPUT   = 8'hD1;
   localparam logic [7:0] CCMD_WRITE_KBD_BUF  = 8'hD2;
   localparam logic [7:0] CCMD_WRITE_AUX_BUF  = 8'hD3;
   localparam logic [7:0] CCMD_WRITE_AUX      = 8'hD4;
   localparam logic [7:0] CCMD_READ_TEST      = 8'hE0;
   localparam logic [7:0] CCMD_PULSE_RESET    = 8'hFE;

   // Keyboard commands written to port 60h.
   localparam logic [7:0] KCMD_SET_LEDS      = 8'hED;
   localparam logic [7:0] KCMD_ECHO          = 8'hEE;
   localparam logic [7:0] KCMD_SCAN_SET      = 8'hF0;
   localparam logic [7:0] KCMD_IDENTIFY      = 8'hF2;
   localparam logic [7:0] KCMD_TYPEMATIC     = 8'hF3;
   localparam logic [7:0] KCMD_ENABLE        = 8'hF4;
   localparam logic [7:0] KCMD_DISABLE       = 8'hF5;
   localparam logic [7:0] KCMD_RESET         = 8'hFF;

   // Reply bytes and fixed values.
   localparam logic [7:0] BYTE_NONE         = 8'h00;
   localparam logic [7:0] BYTE_ACK          = 8'hFA;
   localparam logic [7:0] BYTE_ID_LOW       = 8'hAB;
   localparam logic [7:0] BYTE_ID_HIGH      = 8'h83;
   localparam logic [7:0] BYTE_BAT_OK       = 8'hAA;
   localparam logic [7:0] BYTE_TEST_OK      = 8'h55;
   localparam logic [7:0] BYTE_ECHO         = 8'hEE;
   localparam logic [7:0] BYTE_ALL_ONES     = 8'hFF;
   localparam logic [7:0] BYTE_OUTPORT_BASE = 8'hF1;
   localparam logic [7:0] STATUS_BASE       = 8'h14;
   localparam logic [7:0] CMD_BYTE_RESET    = 8'h45;
   localparam logic [7:0] SCAN_SET_RESET    = 8'h02;
   localparam logic [15:0] DELIVER_RESET    = 16'd1;
   localparam logic [15:0] REREAD_RESET     = 16'd500;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ENQUEUE,
      ST_LOAD,
      ST_RESULT
   } state_type;

   // Scalar controller state kept in flops.
   typedef struct packed {
      logic [7:0]  command_byte;
      logic [7:0]  pending_ctrl;
      logic [7:0]  pending_kbd;
      logic [7:0]  scan_code_set;
      logic [7:0]  output_byte;
      logic        output_full;
      logic        last_write_cmd;
      logic        keyboard_enabled;
      logic        delay_armed;
      logic        a20_gate;
      logic        irq_level;
      logic [2:0]  led_bits;
      logic [15:0] delay_count;
   } regs_type;

   // What one request does, as worked out by the decoder.
   typedef struct packed {
      regs_type        regs;
      logic [2:0][7:0] bytes;
      logic [1:0]      nbytes;
      logic [7:0]      read_data;
      logic            cpu_reset;
      logic            fetch;
   } action_type;

   // Response fields handed from the sequencer to the output register.
   typedef struct packed {
      logic [2:0] led_state;
      logic       cpu_reset;
      logic       a20_enable;
      logic       irq_line;
      logic [7:0] read_data;
   } result_type;

   // A programmed delay of zero counts as one tick.
   function automatic logic [15:0] arm_value(input logic [15:0] ticks);
      return (ticks == 16'd0) ? 16'd1 : ticks;
   endfunction

endpackage

// File: rtl/kbc_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module kbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write on enable, otherwise read the addressed entry.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end else begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/kbc_decode.sv
// Request decoder: works out the state changes, reply bytes and read data
// of one request against the current controller state. Uses kbc_pkg.
module kbc_decode
   import kbc_pkg::*;
(
   input  logic [2:0]  kind,
   input  logic [7:0]  data,
   input  regs_type    cur,
   input  logic        fifo_empty,
   input  logic [15:0] reread_ticks,
   output action_type  act
);

   logic [15:0] count_dec;

   assign count_dec = cur.delay_count - 16'd1;

   always_comb begin
      act      = '0;
      act.regs = cur;
      case (kind)
         // Data port read: hand out the buffer and re-arm for the next byte.
         KIND_READ_DATA: begin
            act.read_data = cur.output_byte;
            if (cur.output_full) begin
               act.regs.output_full = 1'b0;
               act.regs.irq_level   = 1'b0;
               if (!fifo_empty && !cur.delay_armed) begin
                  act.regs.delay_armed = 1'b1;
                  act.regs.delay_count = arm_value(reread_ticks);
               end
            end
         end
         // Status read.
         KIND_READ_STATUS: begin
            act.read_data = STATUS_BASE | {4'd0, cur.last_write_cmd, 2'd0, cur.output_full};
         end
         // Data port write: controller argument, keyboard argument or keyboard command.
         KIND_WRITE_DATA: begin
            act.regs.last_write_cmd = 1'b0;
            if (cur.pending_ctrl != BYTE_NONE) begin
               act.regs.pending_ctrl = BYTE_NONE;
               case (cur.pending_ctrl)
                  CCMD_WRITE_CMD_BYTE: act.regs.command_byte = data;
                  CCMD_WRITE_OUTPUT: begin
                     act.regs.a20_gate = data[1];
                     act.cpu_reset     = !data[0];
                  end
                  CCMD_WRITE_KBD_BUF: begin
                     act.bytes[0] = data;
                     act.nbytes   = 2'd1;
                  end
                  default: ;
               endcase
            end else if (cur.pending_kbd != BYTE_NONE) begin
               act.regs.pending_kbd = BYTE_NONE;
               act.bytes[0]         = BYTE_ACK;
               act.nbytes           = 2'd1;
               case (cur.pending_kbd)
                  KCMD_SET_LEDS: act.regs.led_bits = data[2:0];
                  KCMD_SCAN_SET: begin
                     if (data == BYTE_NONE) begin
                        act.bytes[1] = cur.scan_code_set;
                        act.nbytes   = 2'd2;
                     end else begin
                        act.regs.scan_code_set = data;
                     end
                  end
                  default: ;
               endcase
            end else begin
               act.bytes[0] = BYTE_ACK;
               act.nbytes   = 2'd1;
               case (data)
                  KCMD_SET_LEDS, KCMD_SCAN_SET, KCMD_TYPEMATIC: act.regs.pending_kbd = data;
                  KCMD_ECHO: act.bytes[0] = BYTE_ECHO;
                  KCMD_IDENTIFY: begin
                     act.bytes[1] = BYTE_ID_LOW;
                     act.bytes[2] = BYTE_ID_HIGH;
                     act.nbytes   = 2'd3;
                  end
                  KCMD_ENABLE:  act.regs.keyboard_enabled = 1'b1;
                  KCMD_DISABLE: act.regs.keyboard_enabled = 1'b0;
                  KCMD_RESET: begin
                     act.bytes[1] = BYTE_BAT_OK;
                     act.nbytes   = 2'd2;
                  end
                  default: ;
               endcase
            end
         end
         // Controller command write.
         KIND_WRITE_CMD: begin
            act.regs.last_write_cmd = 1'b1;
            case (data)
               CCMD_READ_CMD_BYTE: begin
                  act.bytes[0] = cur.command_byte;
                  act.nbytes   = 2'd1;
               end
               CCMD_WRITE_CMD_BYTE, CCMD_WRITE_OUTPUT, CCMD_WRITE_KBD_BUF,
               CCMD_WRITE_AUX_BUF, CCMD_WRITE_AUX: act.regs.pending_ctrl = data;
               CCMD_TEST_AUX, CCMD_TEST_KBD: begin
                  act.bytes[0] = BYTE_NONE;
                  act.nbytes   = 2'd1;
               end
               CCMD_SELF_TEST: begin
                  act.bytes[0] = BYTE_TEST_OK;
                  act.nbytes   = 2'd1;
               end
               CCMD_DISABLE_KBD: act.regs.command_byte[4] = 1'b1;
               CCMD_ENABLE_KBD:  act.regs.command_byte[4] = 1'b0;
               CCMD_READ_INPUT, CCMD_READ_TEST: begin
                  act.bytes[0] = BYTE_ALL_ONES;
                  act.nbytes   = 2'd1;
               end
               CCMD_READ_OUTPUT: begin
                  act.bytes[0] = BYTE_OUTPORT_BASE | {6'd0, cur.a20_gate, 1'b0};
                  act.nbytes   = 2'd1;
               end
               CCMD_PULSE_RESET: act.cpu_reset = 1'b1;
               default: ;
            endcase
         end
         // Scancode from the keyboard, queued only while scanning is on.
         KIND_SCANCODE: begin
            if (cur.keyboard_enabled) begin
               act.bytes[0] = data;
               act.nbytes   = 2'd1;
            end
         end
         // Time tick: count down and fetch the head byte on expiry.
         KIND_TICK: begin
            if (cur.delay_armed) begin
               act.regs.delay_count = count_dec;
               if (count_dec == 16'd0) begin
                  act.regs.delay_armed = 1'b0;
                  act.fetch            = !cur.output_full && !fifo_empty;
               end
            end
         end
         default: ;
      endcase
   end

endmodule

// File: rtl/kbc_ctrl.sv
// Sequencer of the keyboard controller: latches a request, applies the
// decoded action, writes reply bytes into the FIFO RAM one per cycle and
// loads the output buffer from it. Uses kbc_pkg, kbc_decode and kbc_ram.
module kbc_ctrl
   import kbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_data,
   input  logic [15:0] deliver_ticks,
   input  logic [15:0] reread_ticks,
   input  logic        out_free,
   output logic        res_valid,
   output result_type  res
);

   state_type state_ff, state_in;

   logic [2:0]         kind_ff, kind_in;
   logic [7:0]         data_ff, data_in;
   regs_type           regs_ff, regs_in;
   logic [2:0][7:0]    bytes_ff, bytes_in;
   logic [1:0]         nbytes_ff, nbytes_in;
   logic [1:0]         idx_ff, idx_in;
   logic [7:0]         rd_ff, rd_in;
   logic               rst_ff, rst_in;
   logic [FIFO_AW-1:0] head_ff, head_in;
   logic [FIFO_AW-1:0] tail_ff, tail_in;
   logic [FIFO_CW-1:0] count_ff, count_in;

   action_type         act;
   logic               ram_we;
   logic [FIFO_AW-1:0] ram_addr;
   logic [7:0]         ram_rdata;
   logic               last_byte;
   regs_type           regs_reset;

   // Reply FIFO storage.
   kbc_ram #(
      .WIDTH (8),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (bytes_ff[idx_ff]),
      .rdata (ram_rdata)
   );

   kbc_decode u_decode (
      .kind         (kind_ff),
      .data         (data_ff),
      .cur          (regs_ff),
      .fifo_empty   (count_ff == '0),
      .reread_ticks (reread_ticks),
      .act          (act)
   );

   // Writes use the tail, the head fetch is issued from the decode cycle.
   assign ram_addr  = (state_ff == ST_ENQUEUE) ? tail_ff : head_ff;
   assign last_byte = (2'(idx_ff + 2'd1) == nbytes_ff);

   always_comb begin
      regs_reset                  = '0;
      regs_reset.command_byte     = CMD_BYTE_RESET;
      regs_reset.scan_code_set    = SCAN_SET_RESET;
      regs_reset.keyboard_enabled = 1'b1;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (act.nbytes != 2'd0)  state_in = ST_ENQUEUE;
            else if (act.fetch)     state_in = ST_LOAD;
            else                    state_in = ST_RESULT;
         end
         ST_ENQUEUE: begin
            if (last_byte) state_in = ST_RESULT;
         end
         ST_LOAD:   state_in = ST_RESULT;
         ST_RESULT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs per state.
   always_comb begin
      kind_in   = kind_ff;
      data_in   = data_ff;
      regs_in   = regs_ff;
      bytes_in  = bytes_ff;
      nbytes_in = nbytes_ff;
      idx_in    = idx_ff;
      rd_in     = rd_ff;
      rst_in    = rst_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      ram_we    = 1'b0;
      res_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            kind_in = req_kind;
            data_in = req_data;
         end
         ST_DECODE: begin
            regs_in   = act.regs;
            bytes_in  = act.bytes;
            nbytes_in = act.nbytes;
            rd_in     = act.read_data;
            rst_in    = act.cpu_reset;
            idx_in    = 2'd0;
         end
         // One reply byte per cycle; a full FIFO drops it.
         ST_ENQUEUE: begin
            idx_in = 2'(idx_ff + 2'd1);
            if (count_ff < FIFO_CW'(FIFO_DEPTH)) begin
               ram_we   = 1'b1;
               tail_in  = (tail_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
               count_in = count_ff + 1'b1;
               if (!regs_ff.output_full && !regs_ff.delay_armed) begin
                  regs_in.delay_armed = 1'b1;
                  regs_in.delay_count = arm_value(deliver_ticks);
               end
            end
         end
         // Head byte arrives from the RAM into the output buffer.
         ST_LOAD: begin
            regs_in.output_byte = ram_rdata;
            regs_in.output_full = 1'b1;
            if (regs_ff.command_byte[0]) regs_in.irq_level = 1'b1;
            head_in  = (head_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            count_in = count_ff - 1'b1;
         end
         ST_RESULT: res_valid = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         regs_ff  <= regs_reset;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         regs_ff  <= regs_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Per-request payload, no reset needed.
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      data_ff   <= data_in;
      bytes_ff  <= bytes_in;
      nbytes_ff <= nbytes_in;
      idx_ff    <= idx_in;
      rd_ff     <= rd_in;
      rst_ff    <= rst_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign res.read_data  = rd_ff;
   assign res.irq_line   = regs_ff.irq_level;
   assign res.a20_enable = regs_ff.a20_gate;
   assign res.cpu_reset  = rst_ff;
   assign res.led_state  = regs_ff.led_bits;

endmodule

// File: rtl/ps2_keyboard_controller_unit.sv
// Top level of the 8042-style PS/2 keyboard controller: configuration
// registers, response output register and the sequencer.
// Uses kbc_pkg and kbc_ctrl.
//
// Usage:
// Each request on the req_ channel is one bus or keyboard event: req_tuser
// gives the kind (read 60h, read 64h, write 60h, write 64h, scancode, tick)
// and req_tdata the byte. Every request yields exactly one response on the
// rsp_ channel, in order, carrying the read byte and the IRQ1, A20 gate,
// CPU reset and LED levels after the request.
// A request passes the decode step, then one enqueue step per reply byte it
// queues (up to three), or a load step when a tick loads the output buffer
// from the reply FIFO, then the result step; the single-port FIFO RAM sets the
// per-byte cost. The response is registered in the cycle after the result step.
// Only one request is worked on at a time. A finished response waits in the
// output register while the next request is accepted; when the receiver
// stalls, the following request completes up to the response step and waits.
// The user is to write the two delay registers on the csr_ port only while
// the controller is idle; the block does not enforce this. The port is always
// ready. Synchronous reset returns the controller state, FIFO pointers and
// delay registers to their defaults; FIFO RAM contents are not cleared.
module ps2_keyboard_controller_unit
   import kbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data
   input  logic [2:0]  req_tuser,   // [2:0] kind
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] read_data, [8] irq_line, [9] a20_enable,
                                    // [10] cpu_reset, [13:11] led_state, [15:14] zero
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   logic [15:0] deliver_ff, deliver_in;
   logic [15:0] reread_ff, reread_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;
   logic        out_free;
   logic        res_valid;
   result_type  res;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   kbc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_kind      (req_tuser),
      .req_data      (req_tdata),
      .deliver_ticks (deliver_ff),
      .reread_ticks  (reread_ff),
      .out_free      (out_free),
      .res_valid     (res_valid),
      .res           (res)
   );

   // Delay register writes.
   always_comb begin
      deliver_in = deliver_ff;
      reread_in  = reread_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DELIVER_DELAY: deliver_in = csr_data;
            CSR_REREAD_DELAY:  reread_in  = csr_data;
            default: ;
         endcase
      end
   end

   // Response output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, res};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deliver_ff   <= DELIVER_RESET;
         reread_ff    <= REREAD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         deliver_ff   <= deliver_in;
         reread_ff    <= reread_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/kbc_checker.sv
// Port-level checks for the keyboard controller, bound to the top level.
// Depends on ps2_keyboard_controller_unit.
module kbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // A stalled response holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // No response is offered right after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

   // One request at a time: no request is taken in the cycle after one.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

   // A reset request never comes from a read, so its read byte is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> rsp_tdata[7:0] == 8'd0)
      else $error("cpu reset with nonzero read data");

   // Padding bits of the response stay zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:14] == 2'b00)
      else $error("response padding not zero");

endmodule

bind ps2_keyboard_controller_unit kbc_checker u_kbc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: bench/ps2_keyboard_controller_unit_test.sv
// Self-checking testbench for the PS/2 keyboard controller: directed port
// sequences, FIFO overflow, random bus traffic and long delays, with
// an in-bench predictor of the controller. Depends on kbc_pkg and the RTL.
`timescale 1ns / 1ps

module ps2_keyboard_controller_unit_test;
   import kbc_pkg::*;

   // Kinds outside the decoded range; the controller must leave them alone.
   localparam logic [2:0] KIND_UNUSED_A = 3'd6;
   localparam logic [2:0] KIND_UNUSED_B = 3'd7;
   localparam int CYCLE_LIMIT = 200_000;
   localparam int PRINT_LIMIT = 30;
   localparam int LONG_DELAY = 80;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data
   logic [2:0]  req_tuser = 3'd0;    // [2:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [7:0] read_data, [8] irq_line, [9] a20_enable,
                                     // [10] cpu_reset, [13:11] led_state, [15:14] zero
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [15:0] csr_data = 16'd0;

   // Idle percentages of the two sides, changed between phases.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   int request_count = 0;
   int response_count = 0;
   int error_count = 0;
   int dropped_count = 0;
   int load_count = 0;
   int cpu_reset_count = 0;
   int cycle_count = 0;

   // Results predicted at request time, oldest first.
   result_type awaited_results[$];

   // Predicted controller state.
   logic [7:0]  reply_mem [FIFO_DEPTH];
   int unsigned rd_ptr, wr_ptr, reply_cnt;
   logic [7:0]  obuf_byte, ctrl_byte, ctrl_wait, kbd_wait, code_set;
   logic        obuf_full, last_was_cmd, kbd_on, counting, gate_a20, irq1;
   logic [2:0]  leds;
   logic [15:0] countdown, dly_deliver, dly_reread;

   ps2_keyboard_controller_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Controller predictor
   // ---------------------------------------------------------------------

   function automatic void init_predictor();
      rd_ptr = 0;
      wr_ptr = 0;
      reply_cnt = 0;
      obuf_byte = 8'h00;
      obuf_full = 1'b0;
      last_was_cmd = 1'b0;
      ctrl_byte = CMD_BYTE_RESET;
      ctrl_wait = BYTE_NONE;
      kbd_wait = BYTE_NONE;
      kbd_on = 1'b1;
      code_set = SCAN_SET_RESET;
      leds = 3'd0;
      countdown = 16'd0;
      counting = 1'b0;
      gate_a20 = 1'b0;
      irq1 = 1'b0;
      dly_deliver = DELIVER_RESET;
      dly_reread = REREAD_RESET;
   endfunction

   // A programmed delay of zero still takes one tick.
   function automatic void start_countdown(input logic [15:0] ticks);
      countdown = ticks;
      if (countdown == 16'd0)
         countdown = 16'd1;
      counting = 1'b1;
   endfunction

   // Queue a reply byte; a full FIFO drops it.
   function automatic void push_reply(input logic [7:0] b);
      if (reply_cnt >= FIFO_DEPTH) begin
         dropped_count++;
         return;
      end
      reply_mem[wr_ptr] = b;
      wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
      reply_cnt++;
      if (!obuf_full && !counting)
         start_countdown(dly_deliver);
   endfunction

   // Move the head byte into an empty output buffer.
   function automatic void load_obuf();
      if (obuf_full || reply_cnt == 0)
         return;
      obuf_byte = reply_mem[rd_ptr];
      rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
      reply_cnt--;
      obuf_full = 1'b1;
      load_count++;
      if (ctrl_byte[0])
         irq1 = 1'b1;
   endfunction

   // Byte that reaches the keyboard: a command or the argument of one.
   function automatic void kbd_write(input logic [7:0] v);
      logic [7:0] c;
      if (kbd_wait != BYTE_NONE) begin
         c = kbd_wait;
         kbd_wait = BYTE_NONE;
         push_reply(BYTE_ACK);
         if (c == KCMD_SET_LEDS) begin
            leds = v[2:0];
         end else if (c == KCMD_SCAN_SET) begin
            if (v == 8'h00)
               push_reply(code_set);
            else
               code_set = v;
         end
         return;
      end
      case (v)
         KCMD_SET_LEDS, KCMD_SCAN_SET, KCMD_TYPEMATIC: begin
            kbd_wait = v;
            push_reply(BYTE_ACK);
         end
         KCMD_ECHO: push_reply(BYTE_ECHO);
         KCMD_IDENTIFY: begin
            push_reply(BYTE_ACK);
            push_reply(BYTE_ID_LOW);
            push_reply(BYTE_ID_HIGH);
         end
         KCMD_ENABLE: begin
            kbd_on = 1'b1;
            push_reply(BYTE_ACK);
         end
         KCMD_DISABLE: begin
            kbd_on = 1'b0;
            push_reply(BYTE_ACK);
         end
         KCMD_RESET: begin
            push_reply(BYTE_ACK);
            push_reply(BYTE_BAT_OK);
         end
         default: push_reply(BYTE_ACK);
      endcase
   endfunction

   // Port 60h write; returns one when it asks for a CPU reset.
   function automatic logic data_port_write(input logic [7:0] v);
      logic [7:0] c;
      last_was_cmd = 1'b0;
      if (ctrl_wait != BYTE_NONE) begin
         c = ctrl_wait;
         ctrl_wait = BYTE_NONE;
         if (c == CCMD_WRITE_CMD_BYTE) begin
            ctrl_byte = v;
         end else if (c == CCMD_WRITE_OUTPUT) begin
            gate_a20 = v[1];
            return !v[0];
         end else if (c == CCMD_WRITE_KBD_BUF) begin
            push_reply(v);
         end
         return 1'b0;
      end
      kbd_write(v);
      return 1'b0;
   endfunction

   // Port 64h write; returns one when it asks for a CPU reset.
   function automatic logic cmd_port_write(input logic [7:0] v);
      last_was_cmd = 1'b1;
      case (v)
         CCMD_READ_CMD_BYTE: push_reply(ctrl_byte);
         CCMD_WRITE_CMD_BYTE, CCMD_WRITE_OUTPUT, CCMD_WRITE_KBD_BUF,
         CCMD_WRITE_AUX_BUF, CCMD_WRITE_AUX: ctrl_wait = v;
         CCMD_TEST_AUX, CCMD_TEST_KBD: push_reply(BYTE_NONE);
         CCMD_SELF_TEST: push_reply(BYTE_TEST_OK);
         CCMD_DISABLE_KBD: ctrl_byte[4] = 1'b1;
         CCMD_ENABLE_KBD: ctrl_byte[4] = 1'b0;
         CCMD_READ_INPUT, CCMD_READ_TEST: push_reply(BYTE_ALL_ONES);
         CCMD_READ_OUTPUT: push_reply(BYTE_OUTPORT_BASE | {6'b000000, gate_a20, 1'b0});
         CCMD_PULSE_RESET: return 1'b1;
         default: ;
      endcase
      return 1'b0;
   endfunction

   // Apply one request to the predicted state and return its response.
   function automatic result_type controller_step(input logic [2:0] kind,
                                                  input logic [7:0] data);
      result_type r;
      logic       rst;
      r.read_data = 8'h00;
      rst = 1'b0;
      case (kind)
         KIND_READ_DATA: begin
            r.read_data = obuf_byte;
            if (obuf_full) begin
               obuf_full = 1'b0;
               irq1 = 1'b0;
               if (reply_cnt != 0 && !counting)
                  start_countdown(dly_reread);
            end
         end
         KIND_READ_STATUS: r.read_data = STATUS_BASE | {4'b0000, last_was_cmd, 2'b00, obuf_full};
         KIND_WRITE_DATA: rst = data_port_write(data);
         KIND_WRITE_CMD: rst = cmd_port_write(data);
         KIND_SCANCODE: begin
            if (kbd_on)
               push_reply(data);
         end
         KIND_TICK: begin
            if (counting) begin
               countdown = countdown - 16'd1;
               if (countdown == 16'd0) begin
                  counting = 1'b0;
                  load_obuf();
               end
            end
         end
         default: ;
      endcase
      if (rst)
         cpu_reset_count++;
      r.irq_line = irq1;
      r.a20_enable = gate_a20;
      r.cpu_reset = rst;
      r.led_state = leds;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Response checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch at response %0d: %s got 0x%0h expected 0x%0h",
                  response_count, what, got, want);
   endtask

   // Compare every accepted response with the oldest prediction, and stall the
   // receiver at random.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[13:0];
         if (awaited_results.size() == 0) begin
            report_mismatch("response with nothing awaited", rsp_tdata, 0);
         end else begin
            want = awaited_results.pop_front();
            if (got.read_data !== want.read_data)
               report_mismatch("read_data", got.read_data, want.read_data);
            if (got.irq_line !== want.irq_line)
               report_mismatch("irq_line", got.irq_line, want.irq_line);
            if (got.a20_enable !== want.a20_enable)
               report_mismatch("a20_enable", got.a20_enable, want.a20_enable);
            if (got.cpu_reset !== want.cpu_reset)
               report_mismatch("cpu_reset", got.cpu_reset, want.cpu_reset);
            if (got.led_state !== want.led_state)
               report_mismatch("led_state", got.led_state, want.led_state);
            response_count++;
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog on the whole run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Send one request, with a random hold-off first, and predict its response
   // at the edge where it is accepted.
   task automatic send_request(input logic [2:0] kind, input logic [7:0] data);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      awaited_results.push_back(controller_step(kind, data));
      request_count++;
   endtask

   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0)
         @(posedge clock);
   endtask

   // Write both delay registers back to back; only called while idle.
   task automatic set_delays(input logic [15:0] deliver_ticks,
                             input logic [15:0] reread_ticks);
      csr_valid <= 1'b1;
      csr_index <= CSR_DELIVER_DELAY;
      csr_data <= deliver_ticks;
      do @(posedge clock); while (!csr_ready);
      dly_deliver = deliver_ticks;
      csr_index <= CSR_REREAD_DELAY;
      csr_data <= reread_ticks;
      do @(posedge clock); while (!csr_ready);
      dly_reread = reread_ticks;
      csr_valid <= 1'b0;
   endtask

   // Read and tick until every queued reply has passed the output buffer.
   task automatic drain_reply_fifo();
      while (reply_cnt != 0 || obuf_full || counting) begin
         if (obuf_full)
            send_request(KIND_READ_DATA, 8'($urandom_range(255)));
         else
            send_request(KIND_TICK, 8'($urandom_range(255)));
      end
   endtask

   function automatic logic [7:0] any_kbd_command();
      case ($urandom_range(9))
         0: return KCMD_SET_LEDS;
         1: return KCMD_ECHO;
         2: return KCMD_SCAN_SET;
         3: return KCMD_IDENTIFY;
         4: return KCMD_TYPEMATIC;
         5: return KCMD_ENABLE;
         6: return KCMD_DISABLE;
         7: return KCMD_RESET;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [7:0] any_ctrl_command();
      case ($urandom_range(16))
         0: return CCMD_READ_CMD_BYTE;
         1: return CCMD_WRITE_CMD_BYTE;
         2: return CCMD_TEST_AUX;
         3: return CCMD_SELF_TEST;
         4: return CCMD_TEST_KBD;
         5: return CCMD_DISABLE_KBD;
         6: return CCMD_ENABLE_KBD;
         7: return CCMD_READ_INPUT;
         8: return CCMD_READ_OUTPUT;
         9: return CCMD_WRITE_OUTPUT;
         10: return CCMD_WRITE_KBD_BUF;
         11: return CCMD_WRITE_AUX_BUF;
         12: return CCMD_WRITE_AUX;
         13: return CCMD_READ_TEST;
         14: return CCMD_PULSE_RESET;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Short port sequences under the reset delay settings.
   task automatic test_directed_sequence();
      // Status and an empty data read straight after reset.
      send_request(KIND_READ_STATUS, 8'h00);
      send_request(KIND_READ_DATA, 8'hFF);
      // Self test reply loads on one tick and raises IRQ1.
      send_request(KIND_WRITE_CMD, CCMD_SELF_TEST);
      send_request(KIND_TICK, 8'h00);
      send_request(KIND_READ_STATUS, 8'h00);
      send_request(KIND_READ_DATA, 8'h00);
      // Output port write: A20 on, and bit 0 low asks for a CPU reset.
      send_request(KIND_WRITE_CMD, CCMD_WRITE_OUTPUT);
      send_request(KIND_WRITE_DATA, 8'h02);
      send_request(KIND_WRITE_CMD, CCMD_READ_OUTPUT);
      send_request(KIND_WRITE_CMD, CCMD_PULSE_RESET);
      // A zero argument to the scan set command reports the current set.
      send_request(KIND_WRITE_DATA, KCMD_SCAN_SET);
      send_request(KIND_WRITE_DATA, 8'h00);
      // Bytes for the absent mouse are swallowed.
      send_request(KIND_WRITE_CMD, CCMD_WRITE_AUX);
      send_request(KIND_WRITE_DATA, 8'hFF);
      // A disabled keyboard drops its scancodes.
      send_request(KIND_WRITE_DATA, KCMD_DISABLE);
      send_request(KIND_SCANCODE, 8'hFF);
      send_request(KIND_WRITE_DATA, KCMD_SET_LEDS);
      send_request(KIND_WRITE_DATA, 8'hFF);
      send_request(KIND_UNUSED_A, 8'hAA);
      send_request(KIND_UNUSED_B, 8'h55);
      // Load the next byte and read it; that arms the reset reread delay.
      send_request(KIND_TICK, 8'hFF);
      send_request(KIND_READ_DATA, 8'h00);
   endtask

   // Overfill the reply FIFO, then drain it with zero delays (one tick each).
   task automatic test_fifo_overflow();
      int i;
      wait_for_idle();
      set_delays(16'd0, 16'd0);
      for (i = 0; i < 90; i++)
         send_request(KIND_WRITE_DATA, KCMD_IDENTIFY);
      send_request(KIND_WRITE_DATA, KCMD_ENABLE);
      send_request(KIND_SCANCODE, 8'h1C);
      send_request(KIND_WRITE_CMD, CCMD_READ_CMD_BYTE);
      drain_reply_fifo();
   endtask

   // Mostly well-formed command sequences with random content, plus noise and
   // commands whose argument never comes.
   task automatic test_random_traffic(input int count, input logic [15:0] deliver_ticks,
                                      input logic [15:0] reread_ticks);
      int         first;
      int         pick;
      logic [7:0] cmd;
      logic [7:0] arg;
      wait_for_idle();
      set_delays(deliver_ticks, reread_ticks);
      first = request_count;
      while (request_count - first < count) begin
         pick = $urandom_range(99);
         if (pick < 28) begin
            send_request(KIND_TICK, 8'($urandom_range(255)));
         end else if (pick < 46) begin
            send_request(KIND_READ_DATA, 8'($urandom_range(255)));
         end else if (pick < 52) begin
            send_request(KIND_READ_STATUS, 8'($urandom_range(255)));
         end else if (pick < 64) begin
            cmd = any_kbd_command();
            send_request(KIND_WRITE_DATA, cmd);
            if ((cmd == KCMD_SET_LEDS || cmd == KCMD_SCAN_SET || cmd == KCMD_TYPEMATIC)
                && $urandom_range(9) != 0) begin
               arg = 8'($urandom_range(255));
               if (cmd == KCMD_SCAN_SET && $urandom_range(1) == 0)
                  arg = 8'h00;
               send_request(KIND_WRITE_DATA, arg);
            end
         end else if (pick < 80) begin
            cmd = any_ctrl_command();
            send_request(KIND_WRITE_CMD, cmd);
            if ((cmd == CCMD_WRITE_CMD_BYTE || cmd == CCMD_WRITE_OUTPUT ||
                 cmd == CCMD_WRITE_KBD_BUF || cmd == CCMD_WRITE_AUX_BUF ||
                 cmd == CCMD_WRITE_AUX) && $urandom_range(9) != 0) begin
               arg = 8'($urandom_range(255));
               // Keep interrupts enabled most of the time.
               if (cmd == CCMD_WRITE_CMD_BYTE && $urandom_range(3) != 0)
                  arg[0] = 1'b1;
               send_request(KIND_WRITE_DATA, arg);
            end
         end else if (pick < 95) begin
            send_request(KIND_SCANCODE, 8'($urandom_range(255)));
         end else if (pick < 98) begin
            send_request(KIND_WRITE_DATA, 8'($urandom_range(255)));
         end else begin
            send_request($urandom_range(1) ? KIND_UNUSED_A : KIND_UNUSED_B,
                         8'($urandom_range(255)));
         end
      end
   endtask

   // Both delays long: a byte must load on exactly the last tick.
   task automatic test_long_delays();
      drain_reply_fifo();
      wait_for_idle();
      set_delays(16'(LONG_DELAY), 16'(LONG_DELAY));
      send_request(KIND_WRITE_CMD, CCMD_WRITE_CMD_BYTE);
      send_request(KIND_WRITE_DATA, CMD_BYTE_RESET);
      send_request(KIND_WRITE_CMD, CCMD_SELF_TEST);
      send_request(KIND_WRITE_CMD, CCMD_TEST_KBD);
      repeat (LONG_DELAY) send_request(KIND_TICK, 8'($urandom_range(255)));
      send_request(KIND_READ_DATA, 8'h00);
      repeat (LONG_DELAY) send_request(KIND_TICK, 8'($urandom_range(255)));
      send_request(KIND_READ_DATA, 8'h00);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------

   initial begin
      init_predictor();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Sender idles less than the receiver.
      send_idle_pct = 32;
      recv_idle_pct = 50;
      test_directed_sequence();
      test_fifo_overflow();
      test_random_traffic(100, 16'd1, 16'd2);

      // The other way round.
      send_idle_pct = 50;
      recv_idle_pct = 32;
      test_random_traffic(100, 16'd3, 16'd0);

      // No idling on either side.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(100, 16'($urandom_range(1, 4)), 16'($urandom_range(1, 6)));
      test_long_delays();

      wait_for_idle();
      repeat (8) @(posedge clock);
      $display("summary: %0d requests sent, %0d responses checked, %0d cycles",
               request_count, response_count, cycle_count);
      $display("summary: %0d buffer loads, %0d bytes dropped on a full FIFO, %0d reset requests",
               load_count, dropped_count, cpu_reset_count);
      if (error_count == 0 && awaited_results.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
